>>> src/priority_round_robin_scheduler_top_defines.svh
// ---------------------------------------------------------------------------
// priority_round_robin_scheduler_top_defines
// assertion macros shared by the scheduler
// ---------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define PRRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define PRRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/prrs_pkg.sv
// ---------------------------------------------------------------------------
// prrs_pkg
// shared widths, codes and types of the priority round robin scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package prrs_pkg;

  // ready queue depth and derived index widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int LEFT_W     = 16;
  localparam int ORDER_W    = 32;
  localparam int TIME_W     = 32;
  localparam int QUANT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // opcodes of an input word
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_QUANTUM   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_ROBIN_ON = 1'b1;

  // reset value of the time quantum register
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;

  // one ready queue entry
  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
    logic [LEFT_W-1:0]  left;
    logic [ORDER_W-1:0] order;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // head search request
  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] count;
  } scan_req_t;

  // head search result
  typedef struct packed {
    logic             done;
    entry_t           best;
    logic [IDX_W-1:0] best_idx;
    entry_t           last;
  } scan_res_t;

  // queue memory read port
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_rd_t;

endpackage

`default_nettype wire

>>> src/prrs_ifs.sv
// ---------------------------------------------------------------------------
// prrs_ifs
// valid/ready channels of the scheduler: input word, result word, config
// ---------------------------------------------------------------------------
`default_nettype none

interface prrs_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [prrs_pkg::ID_W-1:0]    task_id;
  logic [prrs_pkg::PRIO_W-1:0]  task_priority;
  logic [prrs_pkg::LEFT_W-1:0]  burst_length;

  modport source (output valid, opcode, task_id, task_priority, burst_length,
                  input ready);
  modport sink   (input valid, opcode, task_id, task_priority, burst_length,
                  output ready);
endinterface

interface prrs_result_if;
  logic                         valid;
  logic                         ready;
  logic [prrs_pkg::TIME_W-1:0]  tick_time;
  logic                         ran_valid;
  logic [prrs_pkg::ID_W-1:0]    ran_id;
  logic                         ran_finished;
  logic                         arrival_dropped;

  modport source (output valid, tick_time, ran_valid, ran_id, ran_finished,
                  arrival_dropped, input ready);
  modport sink   (input valid, tick_time, ran_valid, ran_id, ran_finished,
                  arrival_dropped, output ready);
endinterface

interface prrs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [prrs_pkg::CFG_IDX_W-1:0]   index;
  logic [prrs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/prrs_queue_ram.sv
// ---------------------------------------------------------------------------
// prrs_queue_ram
// simple dual port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module prrs_queue_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/prrs_head_scan.sv
// ---------------------------------------------------------------------------
// prrs_head_scan
// walks the filled queue entries one a cycle and keeps the most urgent one
// ---------------------------------------------------------------------------
`default_nettype none

module prrs_head_scan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prrs_pkg::scan_req_t req,
  output      prrs_pkg::ram_rd_t   rd,
  input  wire prrs_pkg::entry_t    rdata,
  output      prrs_pkg::scan_res_t res
);

  logic                          busy;
  logic [prrs_pkg::FILL_W-1:0]   issue_idx;
  logic [prrs_pkg::FILL_W-1:0]   count;
  logic                          rd_pend;
  logic [prrs_pkg::IDX_W-1:0]    rd_idx;
  logic                          have_best;
  logic                          done;
  prrs_pkg::entry_t              best;
  logic [prrs_pkg::IDX_W-1:0]    best_idx;
  prrs_pkg::entry_t              last;
  logic                          issue;
  logic                          last_data;
  logic                          take;

  // lower priority number wins, then older entry order
  function automatic logic better(prrs_pkg::entry_t a, prrs_pkg::entry_t b);
    return (a.prio < b.prio) || ((a.prio == b.prio) && (a.order < b.order));
  endfunction

  // read issue and compare enables
  always_comb begin
    issue     = busy && (issue_idx < count);
    rd.re     = issue;
    rd.raddr  = issue_idx[prrs_pkg::IDX_W-1:0];
    last_data = rd_pend && (prrs_pkg::FILL_W'(rd_idx) == (count - prrs_pkg::FILL_W'(1)));
    take      = rd_pend && (!have_best || better(rdata, best));
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      have_best <= 1'b0;
      done      <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= issue;
      if (req.start) begin
        busy      <= 1'b1;
        issue_idx <= '0;
        have_best <= 1'b0;
      end else begin
        if (issue) begin
          issue_idx <= issue_idx + prrs_pkg::FILL_W'(1);
        end
        if (rd_pend) begin
          have_best <= 1'b1;
        end
        if (last_data) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // running best and last entry seen
  always_ff @(posedge clk) begin
    if (req.start) begin
      count <= req.count;
    end
    if (issue) begin
      rd_idx <= issue_idx[prrs_pkg::IDX_W-1:0];
    end
    if (take) begin
      best     <= rdata;
      best_idx <= rd_idx;
    end
    if (rd_pend) begin
      last <= rdata;
    end
  end

  assign res.done     = done;
  assign res.best     = best;
  assign res.best_idx = best_idx;
  assign res.last     = last;

endmodule

`default_nettype wire

>>> src/priority_round_robin_scheduler_top.sv
// result: registered, valid in the cycle after its input word is taken
// input: a word is taken while idle with the result word free; a tick that
//   completes a task or ends a slice with tasks waiting holds off input for
//   the head search, which reads the queue memory one entry a cycle
// reset: synchronous, clears run state, counters, fill count; presets registers;
//   the queue memory is not cleared, the fill count marks the live entries
// ---------------------------------------------------------------------------
// priority_round_robin_scheduler_top
// preemptive priority task scheduler with optional round robin time slicing
// ---------------------------------------------------------------------------
`default_nettype none

`include "priority_round_robin_scheduler_top_defines.svh"

module priority_round_robin_scheduler_top (
  input  wire logic    clk,
  input  wire logic    rst,
  prrs_item_if.sink    item,
  prrs_result_if.source result,
  prrs_cfg_if.sink     cfg
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;
  typedef enum logic {ACT_FINISH, ACT_EXPIRE} act_t;

  state_t                          state;
  act_t                            act;
  logic [prrs_pkg::FILL_W-1:0]     fill;
  logic [prrs_pkg::ORDER_W-1:0]    order_counter;
  logic                            run_active;
  logic [prrs_pkg::ID_W-1:0]       run_task;
  logic [prrs_pkg::PRIO_W-1:0]     run_prio;
  logic [prrs_pkg::LEFT_W-1:0]     run_left;
  logic [prrs_pkg::QUANT_W-1:0]    slice_used;
  logic [prrs_pkg::TIME_W-1:0]     time_count;
  logic [prrs_pkg::QUANT_W-1:0]    time_quantum;
  logic                            round_robin_on;
  logic                            out_valid;

  logic                            item_acc;
  logic                            is_tick;
  logic                            queue_full;
  logic                            queue_empty;
  logic [prrs_pkg::LEFT_W-1:0]     burst_eff;
  logic [prrs_pkg::LEFT_W-1:0]     left_dec;
  logic [prrs_pkg::QUANT_W-1:0]    slice_inc;
  logic                            expire;
  logic                            preempt;
  logic                            need_scan;
  logic                            scan_done;
  logic                            swap_ok;

  prrs_pkg::scan_req_t             scan_req;
  prrs_pkg::scan_res_t             scan_res;
  prrs_pkg::ram_rd_t               ram_rd;
  prrs_pkg::entry_t                ram_rdata;
  logic                            ram_we;
  logic [prrs_pkg::IDX_W-1:0]      ram_waddr;
  prrs_pkg::entry_t                ram_wdata;

  // handshakes
  assign cfg.ready    = 1'b1;
  assign item.ready   = (state == ST_IDLE) && (!out_valid || result.ready);
  assign item_acc     = item.valid && item.ready;
  assign result.valid = out_valid;

  // per-word decode
  always_comb begin
    is_tick     = (item.opcode == prrs_pkg::OP_TICK);
    queue_full  = (fill == prrs_pkg::FILL_W'(prrs_pkg::QUEUE_DEPTH));
    queue_empty = (fill == '0);
    burst_eff   = (item.burst_length == '0) ? prrs_pkg::LEFT_W'(1) : item.burst_length;
    left_dec    = (run_left != '0) ? (run_left - prrs_pkg::LEFT_W'(1)) : '0;
    slice_inc   = (slice_used != '1) ? (slice_used + prrs_pkg::QUANT_W'(1)) : slice_used;
    expire      = round_robin_on && (slice_inc >= time_quantum);
    preempt     = run_active && (item.task_priority < run_prio);
    need_scan   = is_tick && run_active && !queue_empty && ((left_dec == '0) || expire);
    scan_done   = (state == ST_SCAN) && scan_res.done;
    swap_ok     = (scan_res.best.prio <= run_prio);
  end

  // head search start
  assign scan_req.start = item_acc && need_scan;
  assign scan_req.count = fill;

  // queue memory write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[prrs_pkg::IDX_W-1:0];
    ram_wdata = '{task_id: item.task_id, prio: item.task_priority,
                  left: burst_eff, order: order_counter};
    priority if (item_acc && !is_tick && !queue_full && run_active) begin
      ram_we = 1'b1;
      if (preempt) begin
        ram_wdata = '{task_id: run_task, prio: run_prio,
                      left: run_left, order: order_counter};
      end
    end else if (scan_done && (act == ACT_FINISH)) begin
      // fill the hole of the popped head with the last entry
      ram_we    = 1'b1;
      ram_waddr = scan_res.best_idx;
      ram_wdata = scan_res.last;
    end else if (scan_done && swap_ok) begin
      // expired task takes the slot of the dispatched head
      ram_we    = 1'b1;
      ram_waddr = scan_res.best_idx;
      ram_wdata = '{task_id: run_task, prio: run_prio,
                    left: run_left, order: order_counter};
    end else begin
      ram_we = 1'b0;
    end
  end

  prrs_queue_ram #(
    .DEPTH (prrs_pkg::QUEUE_DEPTH),
    .WIDTH (prrs_pkg::ENTRY_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_rd.re),
    .raddr (ram_rd.raddr),
    .rdata (ram_rdata)
  );

  prrs_head_scan u_head_scan (
    .clk   (clk),
    .rst   (rst),
    .req   (scan_req),
    .rd    (ram_rd),
    .rdata (ram_rdata),
    .res   (scan_res)
  );

  // scheduler state, registers and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= ST_IDLE;
      act                    <= ACT_FINISH;
      fill                   <= '0;
      order_counter          <= '0;
      run_active             <= 1'b0;
      run_task               <= '0;
      run_prio               <= '0;
      run_left               <= '0;
      slice_used             <= '0;
      time_count             <= '0;
      time_quantum           <= prrs_pkg::QUANTUM_RESET;
      round_robin_on         <= 1'b1;
      out_valid              <= 1'b0;
      result.tick_time       <= '0;
      result.ran_valid       <= 1'b0;
      result.ran_id          <= '0;
      result.ran_finished    <= 1'b0;
      result.arrival_dropped <= 1'b0;
    end else begin
      // register writes
      if (cfg.valid) begin
        unique case (cfg.index)
          prrs_pkg::REG_TIME_QUANTUM:   time_quantum   <= cfg.data;
          prrs_pkg::REG_ROUND_ROBIN_ON: round_robin_on <= cfg.data[0];
        endcase
      end

      // result word fills on a taken word, drains otherwise
      if (item_acc) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      if (item_acc) begin
        result.tick_time <= time_count;
        if (is_tick) begin
          // one time unit for the running task
          time_count             <= time_count + prrs_pkg::TIME_W'(1);
          result.ran_valid       <= run_active;
          result.ran_id          <= run_active ? run_task : '0;
          result.ran_finished    <= run_active && (left_dec == '0);
          result.arrival_dropped <= 1'b0;
          if (run_active) begin
            if (left_dec == '0) begin
              run_left <= '0;
              if (queue_empty) begin
                run_active <= 1'b0;
                run_task   <= '0;
                run_prio   <= '0;
                slice_used <= '0;
              end else begin
                state <= ST_SCAN;
                act   <= ACT_FINISH;
              end
            end else begin
              run_left <= left_dec;
              if (expire) begin
                slice_used <= '0;
                if (!queue_empty) begin
                  state <= ST_SCAN;
                  act   <= ACT_EXPIRE;
                end
              end else begin
                slice_used <= slice_inc;
              end
            end
          end
        end else begin
          // task arrival
          result.ran_valid       <= 1'b0;
          result.ran_id          <= '0;
          result.ran_finished    <= 1'b0;
          result.arrival_dropped <= queue_full;
          if (!queue_full) begin
            order_counter <= order_counter + prrs_pkg::ORDER_W'(1);
            if (!run_active || preempt) begin
              run_active <= 1'b1;
              run_task   <= item.task_id;
              run_prio   <= item.task_priority;
              run_left   <= burst_eff;
              slice_used <= '0;
            end
            if (run_active) begin
              fill <= fill + prrs_pkg::FILL_W'(1);
            end
          end
        end
      end

      // dispatch once the head is known
      if (scan_done) begin
        state <= ST_IDLE;
        if (act == ACT_FINISH) begin
          run_active <= 1'b1;
          run_task   <= scan_res.best.task_id;
          run_prio   <= scan_res.best.prio;
          run_left   <= scan_res.best.left;
          slice_used <= '0;
          fill       <= fill - prrs_pkg::FILL_W'(1);
        end else if (swap_ok) begin
          run_task      <= scan_res.best.task_id;
          run_prio      <= scan_res.best.prio;
          run_left      <= scan_res.best.left;
          order_counter <= order_counter + prrs_pkg::ORDER_W'(1);
        end
      end
    end
  end

  // checks
  `PRRS_ASSERT_IMP(a_fill_range, 1'b1, fill <= prrs_pkg::FILL_W'(prrs_pkg::QUEUE_DEPTH), "queue fill above depth")
  `PRRS_ASSERT_IMP(a_idle_empty, !run_active, fill == '0, "tasks waiting while nothing runs")
  `PRRS_ASSERT_IMP(a_done_in_scan, scan_res.done, state == ST_SCAN, "head search done outside scan")
  `PRRS_ASSERT_NXT(a_word_result, item_acc, out_valid, "accepted word left no result")

endmodule

`default_nettype wire

>>> bench/prrs_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prrs_tb_pkg
// scoreboard of the scheduler bench: its own copy of the run state and the
// ready queue predicts each result word from the accepted input words, and
// the result words coming out of the block are checked in order against it
// ---------------------------------------------------------------------------
package prrs_tb_pkg;

  import prrs_pkg::*;

  // one expected or observed result word
  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic              ran_finished;
    logic              arrival_dropped;
  } sched_result_t;

  class sched_scoreboard;

    // waiting tasks, only entries below wait_count are live
    logic [ID_W-1:0]    wait_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  wait_prio [QUEUE_DEPTH];
    logic [LEFT_W-1:0]  wait_left [QUEUE_DEPTH];
    logic [ORDER_W-1:0] wait_seq  [QUEUE_DEPTH];
    int unsigned        wait_count;
    logic [ORDER_W-1:0] seq_next;

    // running task and clock
    logic               cur_active;
    logic [ID_W-1:0]    cur_id;
    logic [PRIO_W-1:0]  cur_prio;
    logic [LEFT_W-1:0]  cur_left;
    logic [LEFT_W-1:0]  cur_slice;
    logic [TIME_W-1:0]  now;

    // register copies
    logic [QUANT_W-1:0] quantum;
    logic               rr_on;

    sched_result_t      expected[$];
    int                 errors;

    function new();
      wait_count = 0;
      seq_next   = '0;
      cur_active = 1'b0;
      cur_id     = '0;
      cur_prio   = '0;
      cur_left   = '0;
      cur_slice  = '0;
      now        = '0;
      quantum    = QUANTUM_RESET;
      rr_on      = 1'b1;
      errors     = 0;
    endfunction

    // one line per mismatch
    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int pending();
      return expected.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_TIME_QUANTUM) quantum = data[QUANT_W-1:0];
      else if (idx == REG_ROUND_ROBIN_ON) rr_on = data[0];
    endfunction

    // append a waiting task with a fresh entry order
    function void enqueue(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                          logic [LEFT_W-1:0] left);
      if (wait_count >= QUEUE_DEPTH) return;
      wait_id[wait_count]   = id;
      wait_prio[wait_count] = prio;
      wait_left[wait_count] = left;
      wait_seq[wait_count]  = seq_next;
      seq_next++;
      wait_count++;
    endfunction

    // most urgent waiting task, oldest entry on a tie
    function int unsigned best_waiting();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < wait_count; i++) begin
        if (wait_prio[i] < wait_prio[best] ||
            (wait_prio[i] == wait_prio[best] && wait_seq[i] < wait_seq[best]))
          best = i;
      end
      return best;
    endfunction

    // move the best waiting task into the run slot
    function void start_best();
      int unsigned h;
      h = best_waiting();
      cur_id   = wait_id[h];
      cur_prio = wait_prio[h];
      cur_left = wait_left[h];
      for (int unsigned i = h; i + 1 < wait_count; i++) begin
        wait_id[i]   = wait_id[i+1];
        wait_prio[i] = wait_prio[i+1];
        wait_left[i] = wait_left[i+1];
        wait_seq[i]  = wait_seq[i+1];
      end
      wait_count--;
      cur_active = 1'b1;
      cur_slice  = '0;
    endfunction

    function void pick_next();
      if (wait_count > 0) begin
        start_best();
      end else begin
        cur_active = 1'b0;
        cur_id     = '0;
        cur_prio   = '0;
        cur_left   = '0;
        cur_slice  = '0;
      end
    endfunction

    // predict the result word of one accepted input word
    function void note_word(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                            logic [LEFT_W-1:0] burst);
      sched_result_t      r;
      logic [LEFT_W-1:0]  need;
      logic [ID_W-1:0]    old_id;
      logic [PRIO_W-1:0]  old_prio;
      logic [LEFT_W-1:0]  old_left;
      r = '0;
      r.tick_time = now;
      if (op == OP_ARRIVAL) begin
        need = (burst == '0) ? LEFT_W'(1) : burst;
        if (wait_count >= QUEUE_DEPTH) begin
          r.arrival_dropped = 1'b1;
        end else if (!cur_active) begin
          enqueue(id, prio, need);
          pick_next();
        end else if (prio < cur_prio) begin
          // preemption: the running task goes back with what it has left
          enqueue(cur_id, cur_prio, cur_left);
          cur_id    = id;
          cur_prio  = prio;
          cur_left  = need;
          cur_slice = '0;
        end else begin
          enqueue(id, prio, need);
        end
      end else begin
        now++;
        if (cur_active) begin
          r.ran_valid = 1'b1;
          r.ran_id    = cur_id;
          if (cur_left != '0) cur_left--;
          if (cur_left == '0) begin
            r.ran_finished = 1'b1;
            pick_next();
          end else begin
            if (cur_slice != '1) cur_slice++;
            // slice expiry: rotate only if a waiting task is as urgent
            if (rr_on && cur_slice >= quantum) begin
              if (wait_count > 0 && wait_prio[best_waiting()] <= cur_prio) begin
                old_id   = cur_id;
                old_prio = cur_prio;
                old_left = cur_left;
                start_best();
                enqueue(old_id, old_prio, old_left);
              end
              cur_slice = '0;
            end
          end
        end
      end
      expected.insert(expected.size(), r);
    endfunction

    // compare one result word with the oldest expectation
    task check_word(sched_result_t got);
      sched_result_t want;
      if (expected.size() == 0) begin
        report($sformatf("result word with nothing expected, time %0d", got.tick_time));
        return;
      end
      want = expected.pop_front();
      if (got.tick_time !== want.tick_time)
        report($sformatf("tick_time %0d, want %0d", got.tick_time, want.tick_time));
      if (got.ran_valid !== want.ran_valid)
        report($sformatf("ran_valid %b, want %b at time %0d",
                         got.ran_valid, want.ran_valid, want.tick_time));
      if (got.ran_id !== want.ran_id)
        report($sformatf("ran_id %h, want %h at time %0d",
                         got.ran_id, want.ran_id, want.tick_time));
      if (got.ran_finished !== want.ran_finished)
        report($sformatf("ran_finished %b, want %b at time %0d",
                         got.ran_finished, want.ran_finished, want.tick_time));
      if (got.arrival_dropped !== want.arrival_dropped)
        report($sformatf("arrival_dropped %b, want %b at time %0d",
                         got.arrival_dropped, want.arrival_dropped, want.tick_time));
    endtask

  endclass

endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// bench of the priority round robin scheduler: a directed run through idle
// ticks, zero bursts, preemption, ties and a full queue, then random task
// arrivals and ticks under several quantum and slicing settings, with random
// stalls on both channels and one long hold-off on the result side
// ---------------------------------------------------------------------------
module tb;

  import prrs_pkg::*;
  import prrs_tb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = QUEUE_DEPTH + 8;

  logic clk;
  logic rst;
  int   cycle_count;
  int   sink_hold;
  bit   steady;

  sched_scoreboard sb;

  prrs_item_if   item_ch ();
  prrs_result_if result_ch ();
  prrs_cfg_if    cfg_ch ();

  priority_round_robin_scheduler_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side ready: random stalls, long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        result_ch.ready <= 1'b0;
      end else if (steady) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      sb.check_word('{tick_time: result_ch.tick_time, ran_valid: result_ch.ran_valid,
                      ran_id: result_ch.ran_id, ran_finished: result_ch.ran_finished,
                      arrival_dropped: result_ch.arrival_dropped});
  end

  // offer one input word, maybe after a short gap, and wait for it to be taken
  task send_word(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                 logic [LEFT_W-1:0] burst);
    if (!steady && $urandom_range(99) < 30) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.opcode        <= op;
    item_ch.task_id       <= id;
    item_ch.task_priority <= prio;
    item_ch.burst_length  <= burst;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    sb.note_word(op, id, prio, burst);
  endtask

  // drop valid and let every expected word come out and the block settle
  task wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random arrivals and ticks, ties made likely by a narrow priority band
  task random_words(int count, int arrival_pct);
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [LEFT_W-1:0] burst;
    int                pick;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(99) < arrival_pct) ? OP_ARRIVAL : OP_TICK;
      prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 5) burst = '0;
      else if (pick < 75) burst = LEFT_W'($urandom_range(1, 4));
      else burst = LEFT_W'($urandom_range(5, 40));
      send_word(op, ID_W'($urandom_range(255)), prio, burst);
    end
  endtask

  initial begin
    sb = new();
    sink_hold = 0;
    steady    = 1'b0;
    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.opcode        <= OP_ARRIVAL;
    item_ch.task_id       <= '0;
    item_ch.task_priority <= '0;
    item_ch.burst_length  <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_TIME_QUANTUM;
    cfg_ch.data           <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings, written explicitly
    set_reg(REG_TIME_QUANTUM, 16'd4);
    set_reg(REG_ROUND_ROBIN_ON, 16'h0001);

    // directed: idle tick, zero burst, preemption, ties, full queue
    send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
    send_word(OP_ARRIVAL, 8'hFF, 8'h80, 16'h0000);
    send_word(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF);
    send_word(OP_ARRIVAL, 8'h00, 8'hFF, 16'd6);
    send_word(OP_ARRIVAL, 8'hAA, 8'h00, 16'd2);
    send_word(OP_ARRIVAL, 8'h55, 8'hFF, 16'd1);
    send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
    send_word(OP_TICK, 8'h00, 8'h00, 16'h0000);
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      send_word(OP_ARRIVAL, ID_W'(8'h10 + i), PRIO_W'(8'hF0 + i), LEFT_W'(1 + i % 3));
    send_word(OP_ARRIVAL, 8'h77, 8'h00, 16'h8000);
    send_word(OP_ARRIVAL, 8'hFF, 8'hFF, 16'hFFFF);
    random_words(250, 55);
    wait_idle();

    // shortest quantum
    set_reg(REG_TIME_QUANTUM, 16'd1);
    random_words(150, 45);
    wait_idle();

    // zero quantum acts as one
    set_reg(REG_TIME_QUANTUM, 16'd0);
    random_words(100, 40);
    wait_idle();

    // largest quantum
    set_reg(REG_TIME_QUANTUM, 16'hFFFF);
    random_words(100, 60);
    wait_idle();

    // plain preemptive priority, upper data bits set
    set_reg(REG_TIME_QUANTUM, 16'd3);
    set_reg(REG_ROUND_ROBIN_ON, 16'hFFFE);
    random_words(150, 50);
    wait_idle();

    // slicing back on, long result hold-off, then a stretch with no stalls
    set_reg(REG_ROUND_ROBIN_ON, 16'h0001);
    set_reg(REG_TIME_QUANTUM, 16'd2);
    sink_hold = 300;
    random_words(75, 50);
    steady = 1'b1;
    random_words(100, 50);
    steady = 1'b0;
    wait_idle();

    if (sb.pending() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
